// ----- rtl/core/pfc_pkg.sv -----
// Shared types, constants and lookup functions for the Playfair digram cipher.
`default_nettype none
package pfc_pkg;

	localparam int SQUARE_SIDE = 5;
	localparam int CODE_W      = 5;
	localparam int ROW_W       = SQUARE_SIDE * CODE_W;
	localparam int IDX_W       = 3;
	localparam int CFG_IDX_W   = 3;
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = 1;
	localparam int QCNT_W      = 2;

	localparam logic [CODE_W-1:0] LETTER_X   = 5'd23;
	localparam logic [CODE_W-1:0] LETTER_MAX = 5'd25;

	localparam logic [CFG_IDX_W-1:0] CFG_MODE_IDX = 3'd5;
	localparam logic                 MODE_DECRYPT = 1'b1;

	typedef logic [SQUARE_SIDE-1:0][ROW_W-1:0] square_t;
	typedef logic [CODE_W-1:0]                 code_t;
	typedef logic [IDX_W-1:0]                  idx_t;

	typedef struct packed {
		idx_t row;
		idx_t col;
	} pos_t;

	typedef struct packed {
		logic found;
		pos_t pos;
	} loc_t;

	// One classified digram waiting for substitution.
	typedef struct packed {
		logic err;
		pos_t a;
		pos_t b;
	} entry_t;

	// Last matching cell in row-major order wins; codes above z never match.
	function automatic loc_t locate(square_t sq, code_t letter);
		loc_t res;
		res = '0;
		for (int r = 0; r < SQUARE_SIDE; r++) begin
			for (int c = 0; c < SQUARE_SIDE; c++) begin
				if (letter <= LETTER_MAX && sq[r][c*CODE_W +: CODE_W] == letter) begin
					res.found   = 1'b1;
					res.pos.row = IDX_W'(r);
					res.pos.col = IDX_W'(c);
				end
			end
		end
		return res;
	endfunction

	function automatic code_t cell_code(square_t sq, idx_t row, idx_t col);
		return sq[row][col*CODE_W +: CODE_W];
	endfunction

	// Step one place forward (encrypt) or back (decrypt) with wrap.
	function automatic idx_t shift_idx(idx_t idx, logic decrypt);
		idx_t res;
		if (decrypt) begin
			res = (idx == '0) ? IDX_W'(SQUARE_SIDE - 1) : idx - IDX_W'(1);
		end else begin
			res = (idx == IDX_W'(SQUARE_SIDE - 1)) ? '0 : idx + IDX_W'(1);
		end
		return res;
	endfunction

endpackage
`default_nettype wire

// ----- rtl/core/pfc_front.sv -----
// Front end: accepts a digram, applies the equal-letter rule and locates both letters.
`default_nettype none
module pfc_front (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   start,
	input  wire pfc_pkg::code_t   first_letter,
	input  wire pfc_pkg::code_t   second_letter,
	input  wire pfc_pkg::square_t square,
	input  wire                   queue_full,
	output logic                  busy,
	output logic                  push,
	output pfc_pkg::entry_t       push_entry
);

	logic            valid_s1;
	pfc_pkg::entry_t entry_s1;
	pfc_pkg::code_t  second_fix;
	pfc_pkg::loc_t   loc_a;
	pfc_pkg::loc_t   loc_b;
	pfc_pkg::entry_t entry_d;
	logic            take;

	assign push = valid_s1 && !queue_full;
	// Hold the stage while its transaction cannot move into the queue.
	assign busy = valid_s1 && queue_full;
	assign take = start && !busy;
	assign push_entry = entry_s1;

	always_comb begin
		second_fix    = (first_letter == second_letter) ? pfc_pkg::LETTER_X : second_letter;
		loc_a         = pfc_pkg::locate(square, first_letter);
		loc_b         = pfc_pkg::locate(square, second_fix);
		entry_d.err   = (first_letter == second_fix) || !loc_a.found || !loc_b.found;
		entry_d.a     = loc_a.pos;
		entry_d.b     = loc_b.pos;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (push) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			entry_s1 <= entry_d;
		end
	end

endmodule
`default_nettype wire

// ----- rtl/core/pfc_queue.sv -----
// Short queue of classified digrams between front and back end.
`default_nettype none
module pfc_queue (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   push,
	input  wire pfc_pkg::entry_t  push_entry,
	input  wire                   pop,
	output logic                  full,
	output logic                  empty,
	output pfc_pkg::entry_t       head
);

	pfc_pkg::entry_t                    slots_q [pfc_pkg::QUEUE_DEPTH];
	logic [pfc_pkg::QPTR_W-1:0]         wptr_q;
	logic [pfc_pkg::QPTR_W-1:0]         rptr_q;
	logic [pfc_pkg::QCNT_W-1:0]         count_q;
	logic                               do_pop;

	assign full   = (count_q == pfc_pkg::QCNT_W'(pfc_pkg::QUEUE_DEPTH));
	assign empty  = (count_q == '0);
	assign head   = slots_q[rptr_q];
	assign do_pop = pop && !empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wptr_q <= wptr_q + pfc_pkg::QPTR_W'(1);
			end
			if (do_pop) begin
				rptr_q <= rptr_q + pfc_pkg::QPTR_W'(1);
			end
			if (push && !do_pop) begin
				count_q <= count_q + pfc_pkg::QCNT_W'(1);
			end else if (do_pop && !push) begin
				count_q <= count_q - pfc_pkg::QCNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wptr_q] <= push_entry;
		end
	end

endmodule
`default_nettype wire

// ----- rtl/core/pfc_back.sv -----
// Back end: applies the row, column or rectangle rule, or gives zeros for an error entry, and registers the result.
`default_nettype none
module pfc_back (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   valid,
	input  wire pfc_pkg::entry_t  entry,
	input  wire pfc_pkg::square_t square,
	input  wire                   direction_mode,
	output logic                  done,
	output pfc_pkg::code_t        out_first,
	output pfc_pkg::code_t        out_second,
	output logic                  lookup_error
);

	pfc_pkg::code_t first_d;
	pfc_pkg::code_t second_d;
	logic           dec;

	assign dec = (direction_mode == pfc_pkg::MODE_DECRYPT);

	always_comb begin
		if (entry.err) begin
			first_d  = '0;
			second_d = '0;
		end else if (entry.a.row == entry.b.row) begin
			first_d  = pfc_pkg::cell_code(square, entry.a.row,
				pfc_pkg::shift_idx(entry.a.col, dec));
			second_d = pfc_pkg::cell_code(square, entry.b.row,
				pfc_pkg::shift_idx(entry.b.col, dec));
		end else if (entry.a.col == entry.b.col) begin
			first_d  = pfc_pkg::cell_code(square,
				pfc_pkg::shift_idx(entry.a.row, dec), entry.a.col);
			second_d = pfc_pkg::cell_code(square,
				pfc_pkg::shift_idx(entry.b.row, dec), entry.b.col);
		end else begin
			// Swap columns, keep rows.
			first_d  = pfc_pkg::cell_code(square, entry.a.row, entry.b.col);
			second_d = pfc_pkg::cell_code(square, entry.b.row, entry.a.col);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done         <= 1'b0;
			lookup_error <= 1'b0;
		end else begin
			done <= valid;
			if (valid) begin
				lookup_error <= entry.err;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (valid) begin
			out_first  <= first_d;
			out_second <= second_d;
		end
	end

endmodule
`default_nettype wire

// ----- rtl/core/playfair_digram_cipher.sv -----
// Top level of the Playfair digram cipher: configuration registers and front/queue/back.
//
//  channel  | handshake           | payload
//  ---------+---------------------+-----------------------------------------------
//  input    | start, busy         | first_letter, second_letter
//  result   | done (one cycle)    | out_first, out_second, lookup_error
//  config   | cfg_we              | cfg_index, cfg_data
//
// One digram per cycle while busy is low; a taken transaction passes through the
// locate stage, the queue and the substitution register before its result shows.
// The back end drains the queue every cycle, so busy stays low in steady use.
// Reset clears the key square and mode to zero and empties the pipeline.
// The receiver cannot stall: each result is shown for one cycle only.
`default_nettype none
module playfair_digram_cipher (
	input  wire                                  clk,
	input  wire                                  arst_n,
	input  wire                                  start,
	output logic                                 busy,
	input  wire  [pfc_pkg::CODE_W-1:0]           first_letter,
	input  wire  [pfc_pkg::CODE_W-1:0]           second_letter,
	input  wire                                  cfg_we,
	input  wire  [pfc_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  wire  [pfc_pkg::ROW_W-1:0]            cfg_data,
	output logic                                 done,
	output logic [pfc_pkg::CODE_W-1:0]           out_first,
	output logic [pfc_pkg::CODE_W-1:0]           out_second,
	output logic                                 lookup_error
);

	pfc_pkg::square_t square_q;
	logic             direction_mode_q;
	logic             queue_full;
	logic             queue_empty;
	logic             push;
	pfc_pkg::entry_t  push_entry;
	pfc_pkg::entry_t  head;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			square_q         <= '0;
			direction_mode_q <= 1'b0;
		end else if (cfg_we) begin
			if (cfg_index < pfc_pkg::CFG_IDX_W'(pfc_pkg::SQUARE_SIDE)) begin
				square_q[cfg_index] <= cfg_data;
			end else if (cfg_index == pfc_pkg::CFG_MODE_IDX) begin
				direction_mode_q <= cfg_data[0];
			end
		end
	end

	pfc_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.first_letter (first_letter),
		.second_letter(second_letter),
		.square       (square_q),
		.queue_full   (queue_full),
		.busy         (busy),
		.push         (push),
		.push_entry   (push_entry)
	);

	pfc_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_entry(push_entry),
		.pop       (!queue_empty),
		.full      (queue_full),
		.empty     (queue_empty),
		.head      (head)
	);

	pfc_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.valid         (!queue_empty),
		.entry         (head),
		.square        (square_q),
		.direction_mode(direction_mode_q),
		.done          (done),
		.out_first     (out_first),
		.out_second    (out_second),
		.lookup_error  (lookup_error)
	);

endmodule
`default_nettype wire

// ----- rtl/core/pfc_checker.sv -----
// Port-level checker for the Playfair digram cipher, bound to the top level.
`default_nettype none
module pfc_checker (
	input wire                          clk,
	input wire                          arst_n,
	input wire                          start,
	input wire                          busy,
	input wire                          done,
	input wire [pfc_pkg::CODE_W-1:0]    out_first,
	input wire [pfc_pkg::CODE_W-1:0]    out_second,
	input wire                          lookup_error
);

	logic accept;
	assign accept = start && !busy;

	// Every taken transaction yields its result after the front stage, the queue and the back-end register.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> ##3 done)
		else $error("result missing three cycles after transaction");

	// No result appears without a transaction behind it.
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(accept, 3))
		else $error("result without matching transaction");

	// An error result carries zero letters.
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && lookup_error) |-> (out_first == '0 && out_second == '0))
		else $error("error result with nonzero letters");

	// The back end never stalls, so the front end never pushes back.
	a_never_busy: assert property (@(posedge clk) disable iff (!arst_n)
		!busy)
		else $error("front end stalled");

endmodule

bind playfair_digram_cipher pfc_checker u_pfc_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.start       (start),
	.busy        (busy),
	.done        (done),
	.out_first   (out_first),
	.out_second  (out_second),
	.lookup_error(lookup_error)
);
`default_nettype wire
